@@ sv/cfi_pkg.sv @@
// Package for the contact friction impulse block: sizes, shift codes,
// sequencer states and request types for the shared units.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfi_pkg;

    // Node accumulation
    localparam int MAX_NODES  = 4;
    localparam int NODE_CNT_W = $clog2(MAX_NODES + 1);
    localparam int SUM_W      = 48;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Magnitude cap of the capped intermediate products (2^61)
    localparam logic [63:0] MAG_CAP = 64'h2000_0000_0000_0000;

    // Divider sizes: dividend holds |t| * 2^14 or 2^32
    localparam int DIV_W     = 46;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Square root: one result bit per step
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

    // Vector lanes x, y, z
    localparam logic [1:0] LAST_LANE = 2'd2;

    // Post-multiply shift amounts
    localparam logic [5:0] SH_RAW  = 6'd0;
    localparam logic [5:0] SH_NORM = 6'd14;
    localparam logic [5:0] SH_Q16  = 6'd16;
    localparam logic [5:0] SH_SLD  = 6'd22;
    localparam logic [5:0] SH_THR  = 6'd24;
    localparam logic [5:0] SH_NODE = 6'd28;

    // Configuration space
    localparam int APB_AW = 3;
    localparam logic [0:0] REG_FRICTION = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NODE,
        ST_VN,
        ST_TN,
        ST_SQ,
        ST_SQRT,
        ST_FS,
        ST_THR,
        ST_MDIV,
        ST_MA,
        ST_SA,
        ST_JN,
        ST_PN,
        ST_WM,
        ST_D,
        ST_FD,
        ST_CJ,
        ST_JS,
        ST_OUT
    } state_t;

    // Request to the shared multiplier: magnitudes, shift, cap, result sign
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        logic [5:0]  sh;
        logic        cap;
        logic        neg;
    } mul_req_t;

    // Request to the divider
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [SUM_W-1:0] divisor;
    } div_req_t;

endpackage

`default_nettype wire

@@ sv/cfi_ifs.sv @@
// Valid/ready channel interfaces for contact items and impulse results.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cfi_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [15:0] node_weight;
    logic [31:0]        node_inv_mass;
    logic signed [31:0] rel_vel_x;
    logic signed [31:0] rel_vel_y;
    logic signed [31:0] rel_vel_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [31:0]        impulse_scale;
    logic               diff_mode;

    modport source (
        output valid, op, node_weight, node_inv_mass, rel_vel_x, rel_vel_y, rel_vel_z,
               normal_x, normal_y, normal_z, impulse_scale, diff_mode,
        input  ready
    );
    modport sink (
        input  valid, op, node_weight, node_inv_mass, rel_vel_x, rel_vel_y, rel_vel_z,
               normal_x, normal_y, normal_z, impulse_scale, diff_mode,
        output ready
    );
endinterface

interface cfi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] impulse_x;
    logic signed [31:0] impulse_y;
    logic signed [31:0] impulse_z;
    logic               sticking;
    logic               mass_fault;

    modport source (
        output valid, impulse_x, impulse_y, impulse_z, sticking, mass_fault,
        input  ready
    );
    modport sink (
        input  valid, impulse_x, impulse_y, impulse_z, sticking, mass_fault,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/cfi_mul.sv @@
// Shared 64x64 multiplier: four 32x32 partial products, then shift,
// optional cap at 2^61 and sign. Depends on cfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfi_mul
    import cfi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mul_req_t           req,
    output logic                    done,
    output logic signed [63:0]      res
);

    logic [63:0]        a_reg, a_next;
    logic [63:0]        b_reg, b_next;
    logic [5:0]         sh_reg, sh_next;
    logic               cap_reg, cap_next;
    logic               neg_reg, neg_next;
    logic [127:0]       acc_reg, acc_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [63:0] res_reg, res_next;

    logic [31:0]  x;
    logic [31:0]  y;
    logic [63:0]  pp;
    logic [1:0]   k;
    logic [127:0] pp_sh;
    logic [127:0] q;
    logic [63:0]  mag;

    // Partial product and final shift/cap
    always_comb
    begin
        x     = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        y     = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp    = x * y;
        k     = 2'({1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]});
        pp_sh = {64'd0, pp} << {k, 5'd0};
        q     = acc_reg >> sh_reg;
        mag   = (cap_reg && (q > {64'd0, MAG_CAP})) ? MAG_CAP : q[63:0];
    end

    // Sequencing of the four partial products
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        sh_next   = sh_reg;
        cap_next  = cap_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            sh_next   = req.sh;
            cap_next  = req.cap;
            neg_next  = req.neg;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!cnt_reg[2])
            begin
                acc_next = acc_reg + pp_sh;
                cnt_next = cnt_reg + 3'd1;
            end
            else
            begin
                res_next  = neg_reg ? -$signed(mag) : $signed(mag);
                done_next = 1'b1;
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        sh_reg  <= sh_next;
        cap_reg <= cap_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

@@ sv/cfi_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on cfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfi_div
    import cfi_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire div_req_t         req,
    output logic                  done,
    output logic [DIV_W-1:0]      quo
);

    logic [SUM_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [SUM_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [SUM_W:0] trial;
    logic [SUM_W:0] diff;
    logic           ge;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        ge    = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

@@ sv/cfi_sqrt.sv @@
// Integer square root of a 64-bit value, one result bit per cycle.
// Depends on cfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfi_sqrt
    import cfi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] x,
    output logic             done,
    output logic [31:0]      root
);

    logic [63:0]           x_reg, x_next;
    logic [63:0]           r_reg, r_next;
    logic [63:0]           bit_reg, bit_next;
    logic [SQRT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [63:0] rb;
    logic        ge;

    always_comb
    begin
        rb = r_reg + bit_reg;
        ge = x_reg >= rb;
    end

    // Digit-by-digit step; leading steps with a bit above x leave r at zero
    always_comb
    begin
        x_next    = x_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = x;
            r_next    = '0;
            bit_next  = 64'h4000_0000_0000_0000;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next   = ge ? x_reg - rb : x_reg;
            r_next   = ge ? (r_reg >> 1) + bit_reg : r_reg >> 1;
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

`default_nettype wire

@@ sv/cfi_apb.sv @@
// APB register file holding the friction coefficient.
// Depends on cfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfi_apb
    import cfi_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output logic [15:0]            friction
);

    logic [15:0] friction_reg, friction_next;
    logic [0:0]  index;
    logic        wr;

    assign index = paddr[APB_AW-1:2];
    assign wr    = psel && penable && pwrite;

    // Write decode
    always_comb
    begin
        friction_next = friction_reg;
        if (wr && (index == REG_FRICTION))
        begin
            friction_next = pwdata[15:0];
        end
    end

    // Read decode
    always_comb
    begin
        unique case (index)
            REG_FRICTION: prdata = {16'd0, friction_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            friction_reg <= '0;
        end
        else
        begin
            friction_reg <= friction_next;
        end
    end

    assign pready   = 1'b1;
    assign friction = friction_reg;

endmodule

`default_nettype wire

@@ sv/contact_friction_impulse_top.sv @@
// Top level: sequencer and datapath registers around the shared multiplier,
// divider and square root. Depends on cfi_pkg, cfi_ifs, cfi_mul, cfi_div,
// cfi_sqrt, cfi_apb.
//
// One item at a time. A node item (op 0) adds (weight^2 * inverse mass) >> 28 to
// the impulse factor sum and gives no result. Node items past MAX_NODES since the
// last contact are dropped, and the input stays ready. A contact item (op 1)
// gives one impulse and clears the sum. Every product goes through one 64x64
// multiplier built from four 32x32 partial products. Divisions use a 46-step
// restoring divider, and the tangential magnitude a 32-step square root. In a
// sliding contact the per-lane divisions take the largest share of the time.
// The impulse is offered on the same edge at which the input becomes ready
// again. in_ch.ready is high only while the sequencer is idle. A finished
// impulse is held in the output register until taken; while it is held, the
// next contact waits for out_ch.ready before it finishes. Friction is written at
// byte address 0 over APB; the user must write it only while the block is idle,
// as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module contact_friction_impulse_top
    import cfi_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    cfi_in_if.sink                 in_ch,
    cfi_out_if.source              out_ch
);

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
        begin
            r = 32'sh7fff_ffff;
        end
        else if (x < -64'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Sequencer
    state_t state_reg, state_next;
    logic   launch_reg, launch_next;
    logic [1:0] idx_reg, idx_next;

    // Node accumulation
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [NODE_CNT_W-1:0] cnt_reg, cnt_next;
    logic [30:0]           w2_reg, w2_next;
    logic [31:0]           inv_reg, inv_next;

    // Contact operands
    logic signed [31:0] v_reg [3];
    logic signed [31:0] v_next [3];
    logic signed [15:0] n_reg [3];
    logic signed [15:0] n_next [3];
    logic [31:0]        scale_reg, scale_next;
    logic               diff_reg, diff_next;

    // Intermediates
    logic signed [49:0] acc_reg, acc_next;
    logic signed [35:0] vn_reg, vn_next;
    logic signed [31:0] t_reg [3];
    logic signed [31:0] t_next [3];
    logic [63:0]        ss_reg, ss_next;
    logic [31:0]        mag_reg, mag_next;
    logic [61:0]        fac_reg, fac_next;
    logic               stick_reg, stick_next;
    logic [SUM_W-1:0]   m_reg, m_next;
    logic signed [62:0] w_reg, w_next;
    logic signed [46:0] d_reg, d_next;
    logic signed [62:0] c_reg, c_next;
    logic signed [62:0] j_reg [3];
    logic signed [62:0] j_next [3];

    // Result register
    logic               ovalid_reg, ovalid_next;
    logic signed [31:0] ox_reg, ox_next;
    logic signed [31:0] oy_reg, oy_next;
    logic signed [31:0] oz_reg, oz_next;
    logic               ostick_reg, ostick_next;
    logic               ofault_reg, ofault_next;

    // Unit hookup
    mul_req_t           mul_req;
    logic               mul_done;
    logic signed [63:0] mul_res;
    div_req_t           div_req;
    logic               div_done;
    logic [DIV_W-1:0]   div_quo;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;
    logic [15:0]        friction;

    logic               accept;
    logic               unit_done;
    logic               last;
    logic               fault;
    logic               out_free;
    logic [35:0]        a_val;
    logic signed [31:0] vi;
    logic signed [15:0] ni;
    logic signed [31:0] ti;
    logic signed [62:0] ji;

    assign accept    = in_ch.valid && (state_reg == ST_IDLE);
    assign unit_done = mul_done || div_done || sqrt_done;
    assign last      = idx_reg == LAST_LANE;
    assign fault     = sum_reg == '0;
    assign out_free  = !ovalid_reg || out_ch.ready;
    assign a_val     = vn_reg[35] ? 36'(-vn_reg) : '0;
    assign vi        = v_reg[idx_reg];
    assign ni        = n_reg[idx_reg];
    assign ti        = t_reg[idx_reg];
    assign ji        = j_reg[idx_reg];

    cfi_apb u_apb (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .friction (friction)
    );

    cfi_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .res   (mul_res)
    );

    cfi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    cfi_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .x     (ss_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.op)
                    begin
                        state_next = ST_VN;
                    end
                    else if (cnt_reg < NODE_CNT_W'(MAX_NODES))
                    begin
                        state_next = ST_NODE;
                    end
                end
            end
            ST_NODE: if (unit_done) state_next = ST_IDLE;
            ST_VN:   if (unit_done && last) state_next = ST_TN;
            ST_TN:   if (unit_done && last) state_next = ST_SQ;
            ST_SQ:   if (unit_done && last) state_next = ST_SQRT;
            ST_SQRT: if (unit_done) state_next = ST_FS;
            ST_FS:   if (unit_done) state_next = ST_THR;
            ST_THR:  if (unit_done) state_next = ST_MDIV;
            ST_MDIV:
            begin
                if (unit_done)
                begin
                    state_next = (stick_reg && !diff_reg) ? ST_SA : ST_MA;
                end
            end
            ST_MA:   if (unit_done) state_next = stick_reg ? ST_JN : ST_D;
            ST_JN:   if (unit_done && last) state_next = ST_OUT;
            ST_SA:   if (unit_done) state_next = ST_PN;
            ST_PN:   if (unit_done) state_next = ST_WM;
            ST_WM:   if (unit_done) state_next = last ? ST_OUT : ST_PN;
            ST_D:    if (unit_done) state_next = ST_FD;
            ST_FD:   if (unit_done) state_next = ST_CJ;
            ST_CJ:
            begin
                if (unit_done)
                begin
                    if (!diff_reg)
                    begin
                        state_next = ST_JS;
                    end
                    else
                    begin
                        state_next = last ? ST_OUT : ST_D;
                    end
                end
            end
            ST_JS:   if (unit_done) state_next = last ? ST_OUT : ST_D;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        launch_next = (accept || unit_done)
                   && (state_next != ST_IDLE) && (state_next != ST_OUT);
    end

    // Unit requests
    always_comb
    begin
        in_ch.ready = state_reg == ST_IDLE;
        mul_req     = '0;
        div_req     = '0;
        sqrt_start  = 1'b0;
        unique case (state_reg)
            ST_NODE:
            begin
                mul_req = '{launch_reg, 64'(w2_reg), 64'(inv_reg), SH_NODE, 1'b1, 1'b0};
            end
            ST_VN:
            begin
                mul_req = '{launch_reg, mag64(64'(vi)), mag64(64'(ni)), SH_RAW, 1'b0,
                            vi[31] ^ ni[15]};
            end
            ST_TN:
            begin
                mul_req = '{launch_reg, mag64(64'(vn_reg)), mag64(64'(ni)), SH_RAW, 1'b0,
                            vn_reg[35] ^ ni[15]};
            end
            ST_SQ:
            begin
                mul_req = '{launch_reg, mag64(64'(ti)), mag64(64'(ti)), SH_RAW, 1'b0, 1'b0};
            end
            ST_SQRT:
            begin
                sqrt_start = launch_reg;
            end
            ST_FS:
            begin
                mul_req = '{launch_reg, 64'(friction), 64'(scale_reg), SH_RAW, 1'b0, 1'b0};
            end
            ST_THR:
            begin
                mul_req = '{launch_reg, 64'(fac_reg), 64'(a_val), SH_THR, 1'b1, 1'b0};
            end
            ST_MDIV:
            begin
                div_req = '{launch_reg, DIV_W'(33'h1_0000_0000), sum_reg};
            end
            ST_MA:
            begin
                mul_req = '{launch_reg, 64'(m_reg), 64'(a_val), SH_Q16, 1'b1, 1'b0};
            end
            ST_SA:
            begin
                mul_req = '{launch_reg, 64'(scale_reg), 64'(a_val), SH_Q16, 1'b1, 1'b0};
            end
            ST_JN, ST_PN:
            begin
                mul_req = '{launch_reg, mag64(64'(ni)), 64'(fac_reg), SH_NORM, 1'b1, ni[15]};
            end
            ST_WM:
            begin
                mul_req = '{launch_reg, mag64(64'(w_reg)), 64'(m_reg), SH_Q16, 1'b1,
                            w_reg[62]};
            end
            ST_D:
            begin
                div_req = '{launch_reg, DIV_W'({mag64(64'(ti)), 14'd0}), SUM_W'(mag_reg)};
            end
            ST_FD:
            begin
                mul_req = '{launch_reg, 64'(friction), mag64(64'(d_reg)), SH_RAW, 1'b0,
                            d_reg[46]};
            end
            ST_CJ:
            begin
                mul_req = '{launch_reg, mag64(64'(c_reg)), 64'(fac_reg), SH_SLD, 1'b1,
                            c_reg[62]};
            end
            ST_JS:
            begin
                mul_req = '{launch_reg, mag64(64'(ji)), 64'(scale_reg), SH_Q16, 1'b1, ji[62]};
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    // Datapath register updates
    always_comb
    begin
        logic [SUM_W:0]      sum49;
        logic signed [49:0]  vsum;
        logic signed [63:0]  tdiff;
        logic signed [63:0]  w64;
        logic signed [63:0]  c64;
        logic signed [31:0]  ww;

        sum49 = {1'b0, sum_reg} + (SUM_W + 1)'(mul_res[34:0]);
        vsum  = acc_reg + $signed(mul_res[49:0]);
        tdiff = 64'(vi) - (mul_res >>> 14);
        w64   = mul_res - 64'(ti);
        c64   = (64'(ni) <<< 8) - mul_res;
        ww    = in_ch.node_weight * in_ch.node_weight;

        idx_next    = idx_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        w2_next     = w2_reg;
        inv_next    = inv_reg;
        v_next      = v_reg;
        n_next      = n_reg;
        scale_next  = scale_reg;
        diff_next   = diff_reg;
        acc_next    = acc_reg;
        vn_next     = vn_reg;
        t_next      = t_reg;
        ss_next     = ss_reg;
        mag_next    = mag_reg;
        fac_next    = fac_reg;
        stick_next  = stick_reg;
        m_next      = m_reg;
        w_next      = w_reg;
        d_next      = d_reg;
        c_next      = c_reg;
        j_next      = j_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        oz_next     = oz_reg;
        ostick_next = ostick_reg;
        ofault_next = ofault_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    w2_next    = ww[30:0];
                    inv_next   = in_ch.node_inv_mass;
                    v_next[0]  = in_ch.rel_vel_x;
                    v_next[1]  = in_ch.rel_vel_y;
                    v_next[2]  = in_ch.rel_vel_z;
                    n_next[0]  = in_ch.normal_x;
                    n_next[1]  = in_ch.normal_y;
                    n_next[2]  = in_ch.normal_z;
                    scale_next = in_ch.impulse_scale;
                    diff_next  = in_ch.diff_mode;
                    acc_next   = '0;
                    ss_next    = '0;
                end
            end
            ST_NODE:
            begin
                if (unit_done)
                begin
                    sum_next = sum49[SUM_W] ? SUM_MAX : sum49[SUM_W-1:0];
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_VN:
            begin
                if (unit_done)
                begin
                    acc_next = vsum;
                    vn_next  = 36'(vsum >>> 14);
                end
            end
            ST_TN:
            begin
                if (unit_done)
                begin
                    t_next[idx_reg] = sat32(tdiff);
                end
            end
            ST_SQ:
            begin
                if (unit_done)
                begin
                    ss_next = ss_reg + 64'(mul_res);
                end
            end
            ST_SQRT:
            begin
                if (unit_done)
                begin
                    mag_next = sqrt_root;
                end
            end
            ST_FS, ST_MA, ST_SA:
            begin
                if (unit_done)
                begin
                    fac_next = mul_res[61:0];
                end
            end
            ST_THR:
            begin
                if (unit_done)
                begin
                    stick_next = {32'd0, mag_reg} <= 64'(mul_res);
                end
            end
            ST_MDIV:
            begin
                if (unit_done)
                begin
                    m_next = fault ? SUM_MAX : SUM_W'(div_quo);
                end
            end
            ST_JN, ST_WM, ST_CJ, ST_JS:
            begin
                if (unit_done)
                begin
                    j_next[idx_reg] = mul_res[62:0];
                end
            end
            ST_PN:
            begin
                if (unit_done)
                begin
                    w_next = w64[62:0];
                end
            end
            ST_D:
            begin
                if (unit_done)
                begin
                    if (mag_reg == '0)
                    begin
                        d_next = '0;
                    end
                    else
                    begin
                        d_next = ti[31] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
                    end
                end
            end
            ST_FD:
            begin
                if (unit_done)
                begin
                    c_next = c64[62:0];
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ox_next     = sat32(64'(j_reg[0]));
                    oy_next     = sat32(64'(j_reg[1]));
                    oz_next     = sat32(64'(j_reg[2]));
                    ostick_next = stick_reg;
                    ofault_next = fault;
                    sum_next    = '0;
                    cnt_next    = '0;
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase

        // Lane stepping at the end of each per-lane pass
        if (unit_done && ((state_reg == ST_VN) || (state_reg == ST_TN)
            || (state_reg == ST_SQ) || (state_reg == ST_JN) || (state_reg == ST_WM)
            || (state_reg == ST_JS) || ((state_reg == ST_CJ) && diff_reg)))
        begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
            idx_reg    <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            idx_reg    <= idx_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w2_reg     <= w2_next;
        inv_reg    <= inv_next;
        v_reg      <= v_next;
        n_reg      <= n_next;
        scale_reg  <= scale_next;
        diff_reg   <= diff_next;
        acc_reg    <= acc_next;
        vn_reg     <= vn_next;
        t_reg      <= t_next;
        ss_reg     <= ss_next;
        mag_reg    <= mag_next;
        fac_reg    <= fac_next;
        stick_reg  <= stick_next;
        m_reg      <= m_next;
        w_reg      <= w_next;
        d_reg      <= d_next;
        c_reg      <= c_next;
        j_reg      <= j_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        oz_reg     <= oz_next;
        ostick_reg <= ostick_next;
        ofault_reg <= ofault_next;
    end

    // Result channel
    assign out_ch.valid      = ovalid_reg;
    assign out_ch.impulse_x  = ox_reg;
    assign out_ch.impulse_y  = oy_reg;
    assign out_ch.impulse_z  = oz_reg;
    assign out_ch.sticking   = ostick_reg;
    assign out_ch.mass_fault = ofault_reg;

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Testbench for contact_friction_impulse_top: directed table, then random node/contact
// groups, checked against an in-bench impulse predictor. Depends on cfi_pkg, cfi_ifs
// and the block's RTL.
`timescale 1ns / 1ps

module testbench;
    import cfi_pkg::*;

    localparam logic [APB_AW-1:0] ADDR_FRICTION = {REG_FRICTION, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SPARE    = 3'd4;
    localparam logic              OP_NODE       = 1'b0;
    localparam logic              OP_CONTACT    = 1'b1;
    localparam int                STALL_LIMIT   = 20000;
    localparam logic [63:0]       Q_ONE         = 64'd65536;

    typedef struct {
        logic               op;
        logic signed [15:0] weight;
        logic [31:0]        inv_mass;
        logic signed [31:0] vel [3];
        logic signed [15:0] nrm [3];
        logic [31:0]        scale;
        logic               diff;
    } item_t;

    typedef struct {
        logic signed [31:0] imp [3];
        logic               stick;
        logic               fault;
    } impulse_t;

    typedef struct {
        item_t    it;
        logic     has_exp;
        impulse_t ex;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    cfi_in_if  in_ch ();
    cfi_out_if out_ch ();

    contact_friction_impulse_top dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    // Predictor state
    logic [63:0] fric_q88;
    logic [63:0] factor_sum;
    int          node_cnt;

    impulse_t pending_impulses[$];
    int  errors = 0;
    bit  calm = 1'b0;          // no idling on either side
    int  hold_req = 0;         // receiver hold-off request, in cycles
    int  hold_cnt = 0;
    int  quiet_cycles = 0;
    row_t dir_rows[$];

    // Clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // (a*b) >> sh on magnitudes, capped at 2^61
    function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        logic [127:0] q;
        p = {64'd0, a} * {64'd0, b};
        q = p >> sh;
        if (q[127:64] != 0) return MAG_CAP;
        return (q[63:0] > MAG_CAP) ? MAG_CAP : q[63:0];
    endfunction

    function automatic longint signed_mul(longint s, logic [63:0] k, int sh);
        logic [63:0] mag;
        logic [63:0] r;
        mag = (s < 0) ? -s : s;
        r = mul_shift(mag, k, sh);
        return (s < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b4;
        r = 0;
        b4 = 64'd1 << 62;
        while (b4 > x) b4 >>= 2;
        while (b4 != 0)
        begin
            if (x >= r + b4)
            begin
                x -= r + b4;
                r = (r >> 1) + b4;
            end
            else
                r >>= 1;
            b4 >>= 2;
        end
        return r;
    endfunction

    // Update factor sum, or compute the contact impulse; returns 1 when a result is due
    function automatic bit predict_impulse(item_t it, output impulse_t res);
        longint v [3], n [3], t [3], d [3], j [3];
        longint vnraw, vn, w, c;
        logic [63:0] a, ss, mag, m, thr, ma, sa, term;
        bit stick, fault;
        vnraw = 0;
        ss = 0;
        res = '{default: '0};
        if (it.op == OP_NODE)
        begin
            if (node_cnt < MAX_NODES)
            begin
                w = longint'(it.weight);
                term = mul_shift(w * w, {32'd0, it.inv_mass}, SH_NODE);
                factor_sum = factor_sum + term;
                if (factor_sum > {16'd0, SUM_MAX}) factor_sum = {16'd0, SUM_MAX};
                node_cnt++;
            end
            return 1'b0;
        end
        for (int i = 0; i < 3; i++)
        begin
            v[i] = longint'(it.vel[i]);
            n[i] = longint'(it.nrm[i]);
            vnraw += v[i] * n[i];
        end
        vn = vnraw >>> 14;
        for (int i = 0; i < 3; i++)
        begin
            t[i] = clip32(v[i] - ((vn * n[i]) >>> 14));
            ss += t[i] * t[i];
        end
        a = (vn < 0) ? -vn : 0;
        mag = root_floor(ss);
        for (int i = 0; i < 3; i++)
            d[i] = (mag != 0) ? (t[i] * 16384) / longint'(mag) : 0;
        fault = (factor_sum == 0);
        m = fault ? {16'd0, SUM_MAX} : (64'd1 << 32) / factor_sum;
        thr = mul_shift(fric_q88 * it.scale, a, SH_THR);
        stick = (mag <= thr);
        if (stick && it.diff)
        begin
            ma = mul_shift(m, a, SH_Q16);
            for (int i = 0; i < 3; i++) j[i] = signed_mul(n[i], ma, SH_NORM);
        end
        else if (stick)
        begin
            sa = mul_shift({32'd0, it.scale}, a, SH_Q16);
            for (int i = 0; i < 3; i++)
            begin
                w = -t[i] + signed_mul(n[i], sa, SH_NORM);
                j[i] = signed_mul(w, m, SH_Q16);
            end
        end
        else
        begin
            ma = mul_shift(m, a, SH_Q16);
            for (int i = 0; i < 3; i++)
            begin
                c = n[i] * 256 - longint'(fric_q88) * d[i];
                j[i] = signed_mul(c, ma, SH_SLD);
                if (!it.diff) j[i] = signed_mul(j[i], {32'd0, it.scale}, SH_Q16);
            end
        end
        for (int i = 0; i < 3; i++) res.imp[i] = clip32(j[i]);
        res.stick = stick;
        res.fault = fault;
        factor_sum = 0;
        node_cnt = 0;
        return 1'b1;
    endfunction

    // APB write: setup then access phase
    task automatic reg_write(logic [APB_AW-1:0] addr, logic [31:0] data);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (addr == ADDR_FRICTION) fric_q88 = {48'd0, data[15:0]};
    endtask

    // Offer one transaction, wait for the handshake, record the expected impulse
    task automatic send_item(item_t it, logic has_exp, impulse_t ex);
        impulse_t res;
        while (!calm && $urandom_range(99) < 27)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.op = it.op;
        in_ch.node_weight = it.weight;
        in_ch.node_inv_mass = it.inv_mass;
        in_ch.rel_vel_x = it.vel[0];
        in_ch.rel_vel_y = it.vel[1];
        in_ch.rel_vel_z = it.vel[2];
        in_ch.normal_x = it.nrm[0];
        in_ch.normal_y = it.nrm[1];
        in_ch.normal_z = it.nrm[2];
        in_ch.impulse_scale = it.scale;
        in_ch.diff_mode = it.diff;
        in_ch.valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (in_ch.ready) break;
        end
        if (predict_impulse(it, res))
            pending_impulses.push_back(has_exp ? ex : res);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_ch.valid = 1'b0;
        while (pending_impulses.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    function automatic item_t node_item(logic signed [15:0] w, logic [31:0] im);
        item_t it;
        it = '{default: '0, vel: '{default: '0}, nrm: '{default: '0}};
        it.op = OP_NODE;
        it.weight = w;
        it.inv_mass = im;
        return it;
    endfunction

    function automatic item_t contact_item(logic signed [31:0] vx, logic signed [31:0] vy,
                                           logic signed [31:0] vz, logic signed [15:0] nx,
                                           logic signed [15:0] ny, logic signed [15:0] nz,
                                           logic [31:0] sc, logic df);
        item_t it;
        it = '{default: '0, vel: '{default: '0}, nrm: '{default: '0}};
        it.op = OP_CONTACT;
        it.vel = '{vx, vy, vz};
        it.nrm = '{nx, ny, nz};
        it.scale = sc;
        it.diff = df;
        return it;
    endfunction

    function automatic logic signed [31:0] rand_vel();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(524288)) - 262144;
            2: return 32'sd0;
            default: return $signed($urandom_range(33554432)) - 16777216;
        endcase
    endfunction

    function automatic logic [31:0] rand_u32();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'd0;
            default: return $urandom_range(262144);
        endcase
    endfunction

    // Random item; well-formed groups are built by the caller
    function automatic item_t rand_item(logic op);
        item_t it;
        int ax;
        it = contact_item(rand_vel(), rand_vel(), rand_vel(), 0, 0, 0, rand_u32(),
                          $urandom_range(1));
        if ($urandom_range(1))
        begin
            ax = $urandom_range(2);
            foreach (it.nrm[i])
                it.nrm[i] = (i == ax) ? ($urandom_range(1) ? 16'sd16384 : -16'sd16384)
                                      : $signed(16'($urandom_range(64))) - 16'sd32;
        end
        else
            foreach (it.nrm[i]) it.nrm[i] = $urandom;
        if ($urandom_range(3) == 0) it.vel[0] = $urandom;
        it.op = op;
        it.weight = ($urandom_range(1)) ? $urandom : $signed(16'($urandom_range(32768))) - 16'sd16384;
        it.inv_mass = rand_u32();
        return it;
    endfunction

    // Receiver ready, with hold-off counted here
    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= calm || ($urandom_range(99) >= 27);
    end

    // Result checker and stall watchdog
    always @(posedge clk)
    begin
        impulse_t e;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("%0t stalled", $realtime);
            $display("[contact_friction_impulse_top] ERROR");
            $finish;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_impulses.size() == 0)
            begin
                $display("%0t unexpected impulse transaction", $realtime);
                errors++;
            end
            else
            begin
                e = pending_impulses.pop_front();
                if (out_ch.impulse_x !== e.imp[0] || out_ch.impulse_y !== e.imp[1] ||
                    out_ch.impulse_z !== e.imp[2] || out_ch.sticking !== e.stick ||
                    out_ch.mass_fault !== e.fault)
                begin
                    $display("%0t mismatch exp %0d %0d %0d s%0b f%0b got %0d %0d %0d s%0b f%0b",
                             $realtime, e.imp[0], e.imp[1], e.imp[2], e.stick, e.fault,
                             out_ch.impulse_x, out_ch.impulse_y, out_ch.impulse_z,
                             out_ch.sticking, out_ch.mass_fault);
                    errors++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        impulse_t none;
        impulse_t ex;
        item_t it;
        int sent;
        int groups;
        logic [31:0] fric_set [5];

        none = '{imp: '{default: '0}, stick: 1'b0, fault: 1'b0};
        fric_q88 = 0;
        factor_sum = 0;
        node_cnt = 0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_NODE;
        in_ch.node_weight = '0;
        in_ch.node_inv_mass = '0;
        in_ch.rel_vel_x = '0;
        in_ch.rel_vel_y = '0;
        in_ch.rel_vel_z = '0;
        in_ch.normal_x = '0;
        in_ch.normal_y = '0;
        in_ch.normal_z = '0;
        in_ch.impulse_scale = '0;
        in_ch.diff_mode = 1'b0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: zero sum after reset, unit mass, extremes, dropped nodes
        ex = '{imp: '{0, 0, 0}, stick: 1'b1, fault: 1'b1};
        dir_rows.push_back('{contact_item(0, 0, 0, 16384, 0, 0, 0, 1), 1'b1, ex});
        dir_rows.push_back('{node_item(16384, 32'd65536), 1'b0, none});
        ex = '{imp: '{0, 0, 65536}, stick: 1'b1, fault: 1'b0};
        dir_rows.push_back('{contact_item(0, 0, -65536, 0, 0, 16384, 65536, 1), 1'b1, ex});
        dir_rows.push_back('{node_item(-16'sd32768, 32'hFFFF_FFFF), 1'b0, none});
        dir_rows.push_back('{node_item(16'sd32767, 32'd0), 1'b0, none});
        dir_rows.push_back('{node_item(16'sd0, 32'hFFFF_FFFF), 1'b0, none});
        dir_rows.push_back('{node_item(16'sd1, 32'd1), 1'b0, none});
        dir_rows.push_back('{node_item(16'sd16384, 32'hFFFF_FFFF), 1'b0, none});
        dir_rows.push_back('{contact_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                             -16'sd32768, 16'sd32767, -16'sd32768, 32'hFFFF_FFFF, 0),
                             1'b0, none});
        ex = '{imp: '{32'sh7FFF_FFFF, 0, 0}, stick: 1'b1, fault: 1'b1};
        dir_rows.push_back('{contact_item(-65536, 0, 0, 16384, 0, 0, 65536, 1), 1'b1, ex});
        dir_rows.push_back('{node_item(16384, 32'd65536), 1'b0, none});
        dir_rows.push_back('{contact_item(65536, 0, -65536, 0, 0, 16384, 65536, 0),
                             1'b0, none});
        dir_rows.push_back('{node_item(16384, 32'd131072), 1'b0, none});
        dir_rows.push_back('{contact_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                             16'sd32767, 16'sd32767, 16'sd32767, 32'd0, 0), 1'b0, none});
        dir_rows.push_back('{node_item(-16'sd16384, 32'd65536), 1'b0, none});
        dir_rows.push_back('{contact_item(100000, -50000, -200000, 0, 0, 16384, 32'd98304, 1),
                             1'b0, none});
        foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].has_exp, dir_rows[i].ex);
        drain_results();

        // Random phases over friction settings, unused address once
        reg_write(ADDR_SPARE, 32'hFFFF_FFFF);
        fric_set = '{32'h0000_FFFF, 32'd256, $urandom, 32'd0, $urandom_range(1024)};
        sent = 0;
        for (int ph = 0; ph < 5; ph++)
        begin
            reg_write(ADDR_FRICTION, fric_set[ph]);
            calm = (ph == 3);
            if (ph == 1) hold_req = 700;
            groups = 0;
            while (sent < (ph + 1) * 110)
            begin
                if ($urandom_range(99) < 15)
                begin
                    send_item(rand_item($urandom_range(1)), 1'b0, none);
                    sent++;
                end
                else
                begin
                    repeat ($urandom_range(5))
                    begin
                        send_item(rand_item(OP_NODE), 1'b0, none);
                        sent++;
                    end
                    send_item(rand_item(OP_CONTACT), 1'b0, none);
                    sent++;
                end
                groups++;
                if (ph == 2 && groups == 10)
                begin
                    in_ch.valid = 1'b0;
                    while (pending_impulses.size() != 0) @(negedge clk);
                end
            end
            drain_results();
        end
        calm = 1'b0;

        if (errors == 0 && pending_impulses.size() == 0)
            $display("[contact_friction_impulse_top] OK");
        else
            $display("[contact_friction_impulse_top] ERROR");
        $finish;
    end

endmodule
